[src/mpq_pkg.sv]
// Shared types, codes and default sizes for the max priority queue.
package mpq_pkg;

  localparam int unsigned CapacityDef = 256;
  localparam int unsigned KeyBitsDef  = 32;

  typedef enum logic [1:0] {
    FUNC_ENQ  = 2'd0,
    FUNC_DEQ  = 2'd1,
    FUNC_INC  = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_DEQ   = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] key;
    logic [31:0]        from_seq;
    logic signed [31:0] amount;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        out_seq;
    logic signed [31:0] out_key;
  } out_t;

  // Flags from the shared compare/add unit.
  typedef struct packed {
    logic a_better;
    logic a_seq_ge;
  } alu_flags_t;

endpackage

[src/mpq_store.sv]
// Entry storage: one write port and one registered read port.
module mpq_store #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned KEY_BITS = 32,
  localparam int unsigned AddrW   = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  logic [KEY_BITS-1:0] wr_key_i,
  input  logic [31:0]         wr_seq_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output logic [KEY_BITS-1:0] rd_key_o,
  output logic [31:0]         rd_seq_o
);

  logic [KEY_BITS-1:0] key_mem [DEPTH];
  logic [31:0]         seq_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      seq_mem[wr_addr_i] <= wr_seq_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o <= key_mem[rd_addr_i];
      rd_seq_o <= seq_mem[rd_addr_i];
    end
  end

endmodule

[src/mpq_alu.sv]
// Shared key compare, sequence compare and key adder.
module mpq_alu #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic [KEY_BITS-1:0] a_key_i,
  input  logic [31:0]         a_seq_i,
  input  logic [KEY_BITS-1:0] b_key_i,
  input  logic [31:0]         b_seq_i,
  input  logic [KEY_BITS-1:0] add_i,
  input  logic [31:0]         from_seq_i,
  output logic [KEY_BITS-1:0] sum_o,
  output mpq_pkg::alu_flags_t flags_o
);
  import mpq_pkg::*;

  logic key_gt;
  logic key_eq;

  assign key_gt = $signed(a_key_i) > $signed(b_key_i);
  assign key_eq = a_key_i == b_key_i;

  // Greater key wins; on equal keys the older entry wins.
  assign flags_o.a_better = key_gt || (key_eq && (a_seq_i < b_seq_i));
  assign flags_o.a_seq_ge = a_seq_i >= from_seq_i;
  assign sum_o            = a_key_i + add_i;

endmodule

[src/max_priority_queue_suffix_increase.sv]
// Bounded max priority queue with sequence-tagged keys and suffix increase.
// Operation: enqueue, empty dequeue and unused codes go from the start state straight to the
// result; dequeue and increase first scan every stored entry, and dequeue then moves the last.
// Throughput: one item at a time; the linear scan through the single read port of the entry
// store (one entry read per cycle) sets the dequeue and increase time.
// Reset: asynchronous, active low; empties the queue and sets the next sequence to 1,
// store contents are left as they are.
module max_priority_queue_suffix_increase #(
  parameter int unsigned CAPACITY = mpq_pkg::CapacityDef,
  parameter int unsigned KEY_BITS = mpq_pkg::KeyBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mpq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mpq_pkg::out_t out_data_o
);
  import mpq_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_START   = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_DQ_LAST = 3'd3;
  localparam logic [2:0] S_DQ_MOVE = 3'd4;
  localparam logic [2:0] S_RESP    = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [31:0]         next_seq_q, next_seq_d;
  logic [CntW-1:0]     iss_q, iss_d;
  logic                rd_vld_q, rd_vld_d;
  logic [AddrW-1:0]    rd_idx_q, rd_idx_d;
  logic                out_valid_q, out_valid_d;

  // Payload registers, no reset needed
  in_t                 in_q, in_d;
  out_t                res_q, res_d;
  out_t                out_q, out_d;
  logic [KEY_BITS-1:0] best_key_q, best_key_d;
  logic [31:0]         best_seq_q, best_seq_d;
  logic [AddrW-1:0]    best_idx_q, best_idx_d;

  // Store and shared unit hookup
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [31:0]         wr_seq;
  logic                rd_en;
  logic [AddrW-1:0]    rd_addr;
  logic [KEY_BITS-1:0] rd_key;
  logic [31:0]         rd_seq;
  logic [KEY_BITS-1:0] sum;
  alu_flags_t          flags;

  logic                in_fire;
  logic                full;
  logic [AddrW-1:0]    last_idx;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign full        = (count_q == CntW'(CAPACITY));
  assign last_idx    = AddrW'(count_q - CntW'(1));

  mpq_store #(
    .DEPTH    (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_key_i  (wr_key),
    .wr_seq_i  (wr_seq),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key),
    .rd_seq_o  (rd_seq)
  );

  // Entry just read against the best so far; also adds the increase amount.
  mpq_alu #(
    .KEY_BITS (KEY_BITS)
  ) u_alu (
    .a_key_i    (rd_key),
    .a_seq_i    (rd_seq),
    .b_key_i    (best_key_q),
    .b_seq_i    (best_seq_q),
    .add_i      (KEY_BITS'(in_q.amount)),
    .from_seq_i (in_q.from_seq),
    .sum_o      (sum),
    .flags_o    (flags)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    next_seq_d  = next_seq_q;
    iss_d       = iss_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q;
    in_d        = in_q;
    res_d       = res_q;
    out_d       = out_q;
    best_key_d  = best_key_q;
    best_seq_d  = best_seq_q;
    best_idx_d  = best_idx_q;
    wr_en       = 1'b0;
    wr_addr     = AddrW'(count_q);
    wr_key      = KEY_BITS'(in_q.key);
    wr_seq      = next_seq_q;
    rd_en       = 1'b0;
    rd_addr     = AddrW'(iss_q);

    // Drop the output transfer once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          in_d    = in_data_i;
          state_d = S_START;
        end
      end

      S_START: begin
        iss_d   = '0;
        res_d   = '{status: STATUS_DONE, out_seq: '0, out_key: '0};
        state_d = S_RESP;
        case (in_q.func)
          FUNC_ENQ: begin
            if (full) begin
              res_d.status = STATUS_FULL;
            end else begin
              wr_en      = 1'b1;
              count_d    = count_q + CntW'(1);
              next_seq_d = next_seq_q + 32'd1;
            end
          end
          FUNC_DEQ: begin
            if (count_q == '0) begin
              res_d.status = STATUS_EMPTY;
            end else begin
              state_d = S_SCAN;
            end
          end
          FUNC_INC: begin
            state_d = S_SCAN;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end

      // Stream reads through the store, one entry per cycle, and handle
      // each entry in the following cycle, when its data arrives.
      S_SCAN: begin
        rd_en    = (iss_q < count_q);
        rd_vld_d = rd_en;
        rd_idx_d = rd_addr;
        if (rd_en) begin
          iss_d = iss_q + CntW'(1);
        end
        if (rd_vld_q) begin
          if (in_q.func == FUNC_DEQ) begin
            if ((rd_idx_q == '0) || flags.a_better) begin
              best_key_d = rd_key;
              best_seq_d = rd_seq;
              best_idx_d = rd_idx_q;
            end
          end else if (flags.a_seq_ge) begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_q;
            wr_key  = sum;
            wr_seq  = rd_seq;
          end
        end
        if (!rd_en && !rd_vld_q) begin
          state_d = (in_q.func == FUNC_DEQ) ? S_DQ_LAST : S_RESP;
        end
      end

      S_DQ_LAST: begin
        rd_en    = 1'b1;
        rd_addr  = last_idx;
        rd_vld_d = 1'b1;
        rd_idx_d = last_idx;
        state_d  = S_DQ_MOVE;
      end

      // Move the last entry into the hole left by the winner
      S_DQ_MOVE: begin
        wr_en       = 1'b1;
        wr_addr     = best_idx_q;
        wr_key      = rd_key;
        wr_seq      = rd_seq;
        count_d     = count_q - CntW'(1);
        res_d       = '{status: STATUS_DEQ, out_seq: best_seq_q,
                        out_key: 32'($signed(best_key_q))};
        state_d     = S_RESP;
      end

      // Hold the result until the output register is free
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      next_seq_q  <= 32'd1;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_seq_q  <= next_seq_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q       <= in_d;
    res_q      <= res_d;
    out_q      <= out_d;
    best_key_q <= best_key_d;
    best_seq_q <= best_seq_d;
    best_idx_q <= best_idx_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.func == FUNC_ENQ) && !full)
    |-> ##2 (count_q == CntW'($past(count_q, 2) + CntW'(1))))
    else $error("accepted enqueue did not add an entry");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q != S_IDLE) && (state_q != S_RESP))
    else $error("store written outside an operation");

  a_resp_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RESP) && (!out_valid_q || out_ready_i)) |=> out_valid_q && in_ready_o)
    else $error("result not presented after completion");
`endif

endmodule
